FILE: src/fpa_pkg.sv
// shared types, codes and saturation helpers for the fixed-point alu
`default_nettype none
package fpa_pkg;

    // operation codes carried in the mode field
    typedef enum logic [3:0] {
        MODE_ADD      = 4'd0,
        MODE_SUB      = 4'd1,
        MODE_MUL      = 4'd2,
        MODE_DIV      = 4'd3,
        MODE_GT       = 4'd4,
        MODE_LT       = 4'd5,
        MODE_GE       = 4'd6,
        MODE_LE       = 4'd7,
        MODE_EQ       = 4'd8,
        MODE_NE       = 4'd9,
        MODE_MIN      = 4'd10,
        MODE_MAX      = 4'd11,
        MODE_INC      = 4'd12,
        MODE_DEC      = 4'd13,
        MODE_FROM_INT = 4'd14,
        MODE_TO_INT   = 4'd15
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // work still pending for an item inside the execution pipeline
    typedef enum logic [1:0] {
        CLS_DONE = 2'd0,
        CLS_MUL  = 2'd1,
        CLS_DIV  = 2'd2
    } cls_t;

    // one classified operation as queued between front and back
    typedef struct packed {
        mode_t       mode;
        logic [31:0] a;
        logic [31:0] b;
    } item_t;

    // per-stage payload of the execution pipeline
    typedef struct packed {
        cls_t        cls;
        logic        neg;
        logic [31:0] res;
        status_t     st;
        logic [63:0] acc;
        logic [32:0] rem;
        logic [31:0] den;
    } stage_t;

    typedef struct packed {
        logic [31:0] res;
        status_t     st;
    } sat_t;

    // saturate a magnitude with sign to a word of ww bits
    function automatic sat_t sat_mag(logic [63:0] mag, logic neg, int unsigned ww);
        logic [63:0] hi;
        logic [63:0] lim;
        logic [63:0] val;
        sat_t        r;
        hi  = (64'd1 << (ww - 1)) - 64'd1;
        lim = neg ? hi + 64'd1 : hi;
        r.st = ST_OK;
        if (mag > lim) begin
            r.st = ST_OVF;
            val  = neg ? (~hi) : hi;
        end else begin
            val = neg ? (64'd0 - mag) : mag;
        end
        r.res = val[31:0];
        return r;
    endfunction

    // clamp a signed value to a word of ww bits
    function automatic sat_t clamp_s(logic signed [63:0] v, int unsigned ww);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] val;
        sat_t               r;
        hi   = $signed((64'd1 << (ww - 1)) - 64'd1);
        lo   = ~hi;
        r.st = ST_OK;
        val  = v;
        if (v > hi) begin
            r.st = ST_OVF;
            val  = hi;
        end else if (v < lo) begin
            r.st = ST_OVF;
            val  = lo;
        end
        r.res = val[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/fpa_front.sv
// front stage: accepts transactions, trims operands to the word width
`default_nettype none
module fpa_front #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [71:0]   s_tdata,
    input  wire logic          q_full,
    output logic               q_push,
    output fpa_pkg::item_t     q_item
);
    localparam int WORD_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int PAD    = 32 - WORD_W;

    logic           vld_reg;
    fpa_pkg::item_t item_reg;
    fpa_pkg::item_t item_next;
    logic           acc_in;

    assign q_push   = vld_reg && !q_full;
    assign s_tready = !vld_reg || !q_full;
    assign acc_in   = s_tvalid && s_tready;
    assign q_item   = item_reg;

    // decode mode and sign-extend the low word bits of each operand
    always_comb begin
        item_next.mode = fpa_pkg::mode_t'(s_tdata[3:0]);
        item_next.a    = 32'($signed(s_tdata[35:4] << PAD) >>> PAD);
        item_next.b    = 32'($signed(s_tdata[67:36] << PAD) >>> PAD);
    end

    // holding register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (acc_in) begin
            vld_reg <= 1'b1;
        end else if (q_push) begin
            vld_reg <= 1'b0;
        end
    end

    // holding register payload
    always_ff @(posedge aclk) begin
        if (acc_in) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

FILE: src/fpa_queue.sv
// small queue of classified operations between front and back
`default_nettype none
module fpa_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  fpa_pkg::item_t      push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output fpa_pkg::item_t      head
);
    localparam int DEPTH = 4;

    fpa_pkg::item_t mem_reg [DEPTH];
    logic [1:0]     wr_ptr_reg;
    logic [1:0]     rd_ptr_reg;
    logic [2:0]     count_reg;

    assign full      = (count_reg == 3'(DEPTH));
    assign not_empty = (count_reg != 3'd0);
    assign head      = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 3'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // no write into a full queue unless it is read as well, no read from an empty one
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop) else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: src/fpa_back.sv
// execution pipeline: simple ops, multiplier and a one-bit-per-stage divider
`default_nettype none
module fpa_back #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_not_empty,
    input  fpa_pkg::item_t     q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [39:0]        m_tdata
);
    localparam int          WORD_W   = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int          NUM_W    = WORD_W + FRAC_BITS;
    localparam int          LAST     = NUM_W + 1;
    localparam logic [63:0] NUM_MASK = (64'd1 << NUM_W) - 64'd1;
    localparam logic [63:0] HALF     = (FRAC_BITS == 0) ? 64'd0
                                                        : (64'd1 << (FRAC_BITS - 1));

    fpa_pkg::stage_t stg_reg  [LAST + 1];
    fpa_pkg::stage_t stg_next [LAST + 1];
    logic [LAST:0]   vld_reg;
    logic            en;

    assign en       = !vld_reg[LAST] || m_tready;
    assign q_pop    = en && q_not_empty;
    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = {6'd0, stg_reg[LAST].st, stg_reg[LAST].res};

    // stage 0: simple ops, multiply and divider setup
    logic signed [31:0] a32;
    logic signed [31:0] b32;
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] prod;
    logic [63:0]        mag_a;
    logic [63:0]        mag_b;
    fpa_pkg::sat_t      sr;

    assign a32  = $signed(q_head.a);
    assign b32  = $signed(q_head.b);
    assign a64  = 64'(a32);
    assign b64  = 64'(b32);
    assign prod = a32 * b32;

    always_comb begin
        mag_a = a64[63] ? 64'(-a64) : 64'(a64);
        mag_b = b64[63] ? 64'(-b64) : 64'(b64);
        sr    = '0;
        stg_next[0]     = '0;
        stg_next[0].cls = fpa_pkg::CLS_DONE;
        stg_next[0].st  = fpa_pkg::ST_OK;
        unique case (q_head.mode)
            fpa_pkg::MODE_ADD: begin
                sr = fpa_pkg::clamp_s(a64 + b64, WORD_W);
                stg_next[0].res = sr.res;
                stg_next[0].st  = sr.st;
            end
            fpa_pkg::MODE_SUB: begin
                sr = fpa_pkg::clamp_s(a64 - b64, WORD_W);
                stg_next[0].res = sr.res;
                stg_next[0].st  = sr.st;
            end
            fpa_pkg::MODE_MUL: begin
                stg_next[0].cls = fpa_pkg::CLS_MUL;
                stg_next[0].acc = prod;
                stg_next[0].neg = prod[63];
            end
            fpa_pkg::MODE_DIV: begin
                if (b64 == 64'sd0) begin
                    stg_next[0].st = fpa_pkg::ST_DIVZ;
                end else begin
                    stg_next[0].cls = fpa_pkg::CLS_DIV;
                    stg_next[0].acc = mag_a << FRAC_BITS;
                    stg_next[0].den = mag_b[31:0];
                    stg_next[0].neg = a64[63] ^ b64[63];
                end
            end
            fpa_pkg::MODE_GT: stg_next[0].res = {31'd0, a32 > b32};
            fpa_pkg::MODE_LT: stg_next[0].res = {31'd0, a32 < b32};
            fpa_pkg::MODE_GE: stg_next[0].res = {31'd0, a32 >= b32};
            fpa_pkg::MODE_LE: stg_next[0].res = {31'd0, a32 <= b32};
            fpa_pkg::MODE_EQ: stg_next[0].res = {31'd0, a32 == b32};
            fpa_pkg::MODE_NE: stg_next[0].res = {31'd0, a32 != b32};
            fpa_pkg::MODE_MIN: stg_next[0].res = (a32 < b32) ? q_head.a : q_head.b;
            fpa_pkg::MODE_MAX: stg_next[0].res = (a32 > b32) ? q_head.a : q_head.b;
            fpa_pkg::MODE_INC: begin
                sr = fpa_pkg::clamp_s(a64 + 64'sd1, WORD_W);
                stg_next[0].res = sr.res;
                stg_next[0].st  = sr.st;
            end
            fpa_pkg::MODE_DEC: begin
                sr = fpa_pkg::clamp_s(a64 - 64'sd1, WORD_W);
                stg_next[0].res = sr.res;
                stg_next[0].st  = sr.st;
            end
            fpa_pkg::MODE_FROM_INT: begin
                sr = fpa_pkg::sat_mag(mag_a << FRAC_BITS, a64[63], WORD_W);
                stg_next[0].res = sr.res;
                stg_next[0].st  = sr.st;
            end
            fpa_pkg::MODE_TO_INT: stg_next[0].res = 32'(a64 >>> FRAC_BITS);
        endcase
    end

    // stages 1..LAST: divider steps, multiply rounding, divide rounding
    for (genvar k = 1; k <= LAST; k++) begin : g_stage
        fpa_pkg::stage_t cur;
        logic [32:0]     rem_sh;
        logic            qbit;
        logic            rnd;
        logic [63:0]     mag;
        fpa_pkg::sat_t   fin;

        assign cur = stg_reg[k - 1];

        always_comb begin
            stg_next[k] = cur;
            rem_sh      = {cur.rem[31:0], cur.acc[NUM_W - 1]};
            qbit        = 1'b0;
            rnd         = 1'b0;
            mag         = 64'd0;
            fin         = '0;
            if (k <= NUM_W) begin
                // one quotient bit per stage
                if (cur.cls == fpa_pkg::CLS_DIV) begin
                    if (rem_sh >= {1'b0, cur.den}) begin
                        qbit            = 1'b1;
                        stg_next[k].rem = rem_sh - {1'b0, cur.den};
                    end else begin
                        stg_next[k].rem = rem_sh;
                    end
                    stg_next[k].acc = {cur.acc[62:0], qbit};
                end
                // product rounding half away from zero
                if (k == 1 && cur.cls == fpa_pkg::CLS_MUL) begin
                    mag = cur.neg ? (64'd0 - cur.acc) : cur.acc;
                    fin = fpa_pkg::sat_mag((mag + HALF) >> FRAC_BITS, cur.neg, WORD_W);
                    stg_next[k].res = fin.res;
                    stg_next[k].st  = fin.st;
                    stg_next[k].cls = fpa_pkg::CLS_DONE;
                end
            end else if (cur.cls == fpa_pkg::CLS_DIV) begin
                // quotient rounding from the final remainder
                rnd = ({cur.rem, 1'b0} >= {2'b00, cur.den});
                mag = (cur.acc & NUM_MASK) + 64'(rnd);
                fin = fpa_pkg::sat_mag(mag, cur.neg, WORD_W);
                stg_next[k].res = fin.res;
                stg_next[k].st  = fin.st;
                stg_next[k].cls = fpa_pkg::CLS_DONE;
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST - 1:0], q_not_empty};
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= LAST; i++) begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stg_reg[LAST].st == fpa_pkg::ST_DIVZ |-> stg_reg[LAST].res == 32'd0)
        else $error("divide by zero with nonzero result");
    a_done_at_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> stg_reg[LAST].cls == fpa_pkg::CLS_DONE)
        else $error("unfinished item at output");
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        en && q_not_empty |=> vld_reg[0])
        else $error("popped item lost at stage 0");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> stg_reg[LAST].st != 2'd3)
        else $error("undefined status code");

endmodule
`default_nettype wire

FILE: src/fixed_point_alu.sv
// Signed fixed-point ALU: front register, four-entry queue, execution pipeline.
// Every item passes through the whole execution pipeline, whose depth is set by the
// one-quotient-bit-per-stage divider. Throughput: one transaction per cycle; the whole
// back pipeline holds while a result waits on m_tready, and the queue keeps the input
// side taking items until it fills.
// Reset: synchronous active-low aresetn empties the front register, queue and pipeline.
`default_nettype none
module fixed_point_alu #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // mode[3:0], operand_a[35:4], operand_b[67:36], zeros
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // result_value[31:0], status[33:32], zeros
);
    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_not_empty;
    fpa_pkg::item_t q_in;
    fpa_pkg::item_t q_head;

    // input side
    fpa_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_in)
    );

    // decoupling queue
    fpa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_item(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    // execution side
    fpa_back #(
        .FRAC_BITS (FRAC_BITS),
        .DATA_WIDTH(DATA_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

FILE: bench/fpa_checker.sv
// checker for the fixed-point alu: watches both channels, predicts results and compares
`timescale 1ns / 1ps
module fpa_checker #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);
    localparam int WW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

    typedef struct packed {
        logic [31:0]      value;
        fpa_pkg::status_t st;
    } alu_result_t;

    alu_result_t expected_results[$];

    // sign-extend the low word bits of a field
    function automatic logic signed [63:0] to_word(logic [31:0] f);
        logic signed [63:0] v;
        v = $signed({32'd0, f} << (64 - WW)) >>> (64 - WW);
        return v;
    endfunction

    // saturate to the word range
    function automatic alu_result_t saturate(logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        alu_result_t        r;
        hi = (64'sd1 <<< (WW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        r.st = fpa_pkg::ST_OK;
        if (v > hi) begin
            v = hi;
            r.st = fpa_pkg::ST_OVF;
        end else if (v < lo) begin
            v = lo;
            r.st = fpa_pkg::ST_OVF;
        end
        r.value = v[31:0];
        return r;
    endfunction

    // expected result of one operation
    function automatic alu_result_t alu_predict(logic [71:0] d);
        fpa_pkg::mode_t     op;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] p;
        logic [63:0]        ma;
        logic [63:0]        mb;
        logic [63:0]        q;
        logic [127:0]       num;
        alu_result_t        r;
        op = fpa_pkg::mode_t'(d[3:0]);
        a  = to_word(d[35:4]);
        b  = to_word(d[67:36]);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        r.st = fpa_pkg::ST_OK;
        r.value = '0;
        case (op)
            fpa_pkg::MODE_ADD: r = saturate(a + b);
            fpa_pkg::MODE_SUB: r = saturate(a - b);
            fpa_pkg::MODE_MUL: begin
                p = a * b;
                q = p < 0 ? -p : p;
                if (FRAC_BITS > 0) q = (q + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r = saturate(p < 0 ? -$signed(q) : $signed(q));
            end
            fpa_pkg::MODE_DIV: begin
                if (b == 0) begin
                    r.st = fpa_pkg::ST_DIVZ;
                end else begin
                    num = {64'd0, ma} << FRAC_BITS;
                    q = ((2 * num) + mb) / (2 * {64'd0, mb});
                    r = saturate(((a < 0) != (b < 0)) ? -$signed(q) : $signed(q));
                end
            end
            fpa_pkg::MODE_GT:  r.value = {31'd0, a > b};
            fpa_pkg::MODE_LT:  r.value = {31'd0, a < b};
            fpa_pkg::MODE_GE:  r.value = {31'd0, a >= b};
            fpa_pkg::MODE_LE:  r.value = {31'd0, a <= b};
            fpa_pkg::MODE_EQ:  r.value = {31'd0, a == b};
            fpa_pkg::MODE_NE:  r.value = {31'd0, a != b};
            fpa_pkg::MODE_MIN: r.value = (a < b) ? a[31:0] : b[31:0];
            fpa_pkg::MODE_MAX: r.value = (a > b) ? a[31:0] : b[31:0];
            fpa_pkg::MODE_INC: r = saturate(a + 1);
            fpa_pkg::MODE_DEC: r = saturate(a - 1);
            fpa_pkg::MODE_FROM_INT: begin
                q = ma << FRAC_BITS;
                r = saturate(a < 0 ? -$signed(q) : $signed(q));
            end
            default: r.value = 32'(a >>> FRAC_BITS);
        endcase
        return r;
    endfunction

    assign pending_count = expected_results.size();

    // predict on input transactions, compare on output transactions
    always @(posedge aclk) begin
        alu_result_t want;
        if (!aresetn) begin
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (s_tvalid && s_tready) expected_results.push_back(alu_predict(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tdata[33:32] !== want.st ||
                        m_tdata[39:34] !== 6'd0) begin
                        if (fail_count < 10)
                            $display("mismatch: expected value %h status %0d, got %h status %0d",
                                     want.value, want.st, m_tdata[31:0], m_tdata[33:32]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: bench/tb_fixed_point_alu.sv
// testbench top for the fixed-point alu: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_fixed_point_alu;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          result_count;
    bit          long_hold = 1'b0;

    always #5 aclk = ~aclk;

    fixed_point_alu dut (.*);

    fpa_checker checker_i (.*);

    // send one transaction, honoring the handshake
    task automatic send_op(fpa_pkg::mode_t op, logic [31:0] a, logic [31:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, b, a, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 600))
                                           : -32'($urandom_range(0, 600));
            3: return 32'($signed($urandom) >>> $urandom_range(8, 31));
            default: return $urandom;
        endcase
    endfunction

    // receiver stalls, with one long hold-off
    always @(posedge aclk) begin
        if (long_hold) m_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_tready <= ($urandom_range(0, 2) != 0);
    end

    initial begin
        int k;
        int m;
        int gap;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: every operation on extreme and special operands
        for (m = 0; m < 16; m++)
            send_op(fpa_pkg::mode_t'(m), 32'h7fff_ffff, 32'h8000_0000);
        send_op(fpa_pkg::MODE_DIV, 32'h0000_0100, 32'd0);
        send_op(fpa_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_op(fpa_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(fpa_pkg::MODE_DIV, 32'd3, 32'd6);
        send_op(fpa_pkg::MODE_DIV, -32'd3, 32'd6);
        send_op(fpa_pkg::MODE_MUL, 32'd1, 32'h0000_0080);
        send_op(fpa_pkg::MODE_MIN, 32'd5, 32'd5);
        send_op(fpa_pkg::MODE_DEC, 32'h8000_0000, 32'd0);
        send_op(fpa_pkg::MODE_INC, 32'h7fff_ffff, 32'd0);
        send_op(fpa_pkg::MODE_TO_INT, 32'hffff_ffff, 32'd0);
        // pause until everything has drained
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        // long receiver hold-off while the sender keeps going
        long_hold <= 1'b1;
        fork
            begin
                repeat (200) @(posedge aclk);
                long_hold <= 1'b0;
            end
            for (k = 0; k < 100; k++)
                send_op(fpa_pkg::mode_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
        join
        // random bursts with gaps
        for (k = 0; k < 1000; k++) begin
            send_op(fpa_pkg::mode_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
            if ($urandom_range(0, 15) == 0) begin
                gap = $urandom_range(1, 12);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("ran all 16 operations on directed extremes and random operands");
        $display("results checked: %0d, with bursty input and receiver back-pressure", result_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
src/fpa_pkg.sv
src/fpa_front.sv
src/fpa_queue.sv
src/fpa_back.sv
src/fixed_point_alu.sv
bench/fpa_checker.sv
bench/tb_fixed_point_alu.sv
